[hw/rtl/ssym_pkg.sv]
// Shared types, operation codes and constants of the scoped symbol table.
package ssym_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam int ID_W     = 16;
    localparam int TYPE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int DEPTH_W  = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int REMOVED_W = 7;

    localparam logic [FUNC_W-1:0] OP_DEFINE = 2'd0;
    localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [DEPTH_W-1:0]  sym_depth;
        logic [OFFSET_W-1:0] sym_offset;
        logic [TYPE_W-1:0]   sym_type;
        logic [ID_W-1:0]     sym_id;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TYPE_W-1:0]    found_type;
        logic [OFFSET_W-1:0]  found_offset;
        logic [DEPTH_W-1:0]   found_depth;
        logic [REMOVED_W-1:0] removed_count;
    } result_t;

    typedef enum logic [2:0] {
        RES_DEFINE,
        RES_FULL,
        RES_HIT,
        RES_MISS,
        RES_REMOVE,
        RES_NONE
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     wr_define;
        logic     rd_issue;
        logic     rd_down;
        logic     rm_take;
        logic     set_count;
        logic     res_load;
        res_sel_t res_sel;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              full;
        logic              rd_zero;
        logic              rd_at_count;
        logic              rd_pend;
        logic              id_hit;
    } dp_status_t;

endpackage

[hw/rtl/ssym_dp.sv]
// Datapath of the symbol table: entry memory, count, scan pointers and result registers.
module ssym_dp #(
    parameter int ENTRIES = ssym_pkg::ENTRIES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ssym_pkg::dp_cmd_t                   cmd,
    output ssym_pkg::dp_status_t                st,
    input  logic [ssym_pkg::FUNC_W-1:0]         in_func,
    input  ssym_pkg::entry_t                    in_entry,
    output ssym_pkg::result_t                   out_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    ssym_pkg::entry_t mem [ENTRIES];

    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]               gone_reg, gone_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [ssym_pkg::FUNC_W-1:0] op_reg, op_next;
    ssym_pkg::entry_t            item_reg, item_next;
    ssym_pkg::entry_t            rdata_reg;
    ssym_pkg::result_t           res_reg, res_next;
    ssym_pkg::result_t           out_reg, out_next;

    logic [CW-1:0]    rd_ptr_dec;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    ssym_pkg::entry_t mem_wd;
    logic             depth_hit;

    assign rd_ptr_dec = rd_ptr_reg - CW'(1);
    assign rd_addr    = cmd.rd_down ? rd_ptr_dec[AW-1:0] : rd_ptr_reg[AW-1:0];
    assign depth_hit  = (rdata_reg.sym_depth == item_reg.sym_depth);

    assign mem_we = cmd.wr_define || (cmd.rm_take && !depth_hit);
    assign mem_wa = cmd.wr_define ? count_reg[AW-1:0] : wr_ptr_reg[AW-1:0];
    assign mem_wd = cmd.wr_define ? item_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        gone_next    = gone_reg;
        rd_pend_next = cmd.rd_issue;
        op_next      = op_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        out_next     = out_reg;

        if (cmd.load) begin
            op_next     = in_func;
            item_next   = in_entry;
            rd_ptr_next = (in_func == ssym_pkg::OP_LOOKUP) ? count_reg : '0;
            wr_ptr_next = '0;
            gone_next   = '0;
        end
        if (cmd.rd_issue) begin
            rd_ptr_next = cmd.rd_down ? rd_ptr_dec : rd_ptr_reg + CW'(1);
        end
        if (cmd.rm_take) begin
            if (depth_hit) begin
                gone_next = gone_reg + CW'(1);
            end else begin
                wr_ptr_next = wr_ptr_reg + CW'(1);
            end
        end
        if (cmd.wr_define) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_count) begin
            count_next = wr_ptr_reg;
        end

        if (cmd.res_load) begin
            res_next = '0;
            case (cmd.res_sel)
                ssym_pkg::RES_DEFINE: begin
                    res_next.status       = ssym_pkg::ST_OK;
                    res_next.found_type   = item_reg.sym_type;
                    res_next.found_offset = item_reg.sym_offset;
                    res_next.found_depth  = item_reg.sym_depth;
                end
                ssym_pkg::RES_FULL: begin
                    res_next.status = ssym_pkg::ST_FULL;
                end
                ssym_pkg::RES_HIT: begin
                    res_next.status       = ssym_pkg::ST_OK;
                    res_next.found_type   = rdata_reg.sym_type;
                    res_next.found_offset = rdata_reg.sym_offset;
                    res_next.found_depth  = rdata_reg.sym_depth;
                end
                ssym_pkg::RES_MISS: begin
                    res_next.status = ssym_pkg::ST_NOT_FOUND;
                end
                ssym_pkg::RES_REMOVE: begin
                    res_next.status        = ssym_pkg::ST_OK;
                    res_next.removed_count = ssym_pkg::REMOVED_W'(gone_reg);
                end
                default: begin
                    res_next.status = ssym_pkg::ST_OK;
                end
            endcase
        end
        if (cmd.emit) begin
            out_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
        end
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        gone_reg   <= gone_next;
        op_reg     <= op_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign st.op          = op_reg;
    assign st.full        = (count_reg >= CW'(ENTRIES));
    assign st.rd_zero     = (rd_ptr_reg == '0);
    assign st.rd_at_count = (rd_ptr_reg == count_reg);
    assign st.rd_pend     = rd_pend_reg;
    assign st.id_hit      = rd_pend_reg && (rdata_reg.sym_id == item_reg.sym_id);

    assign out_result = out_reg;

endmodule

[hw/rtl/ssym_ctrl.sv]
// Controller state machine of the symbol table: handshakes and operation sequencing.
module ssym_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ssym_pkg::dp_cmd_t    cmd,
    input  ssym_pkg::dp_status_t st
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_REMOVE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.res_sel   = ssym_pkg::RES_NONE;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (st.op)
                    ssym_pkg::OP_DEFINE: begin
                        cmd.res_load = 1'b1;
                        if (st.full) begin
                            cmd.res_sel = ssym_pkg::RES_FULL;
                        end else begin
                            cmd.wr_define = 1'b1;
                            cmd.res_sel   = ssym_pkg::RES_DEFINE;
                        end
                        state_next = S_EMIT;
                    end
                    ssym_pkg::OP_LOOKUP: begin
                        state_next = S_LOOKUP;
                    end
                    ssym_pkg::OP_REMOVE: begin
                        state_next = S_REMOVE;
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = ssym_pkg::RES_NONE;
                        state_next   = S_EMIT;
                    end
                endcase
            end
            S_LOOKUP: begin
                cmd.rd_down = 1'b1;
                if (st.id_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = ssym_pkg::RES_HIT;
                    state_next   = S_EMIT;
                end else if (st.rd_zero && !st.rd_pend) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = ssym_pkg::RES_MISS;
                    state_next   = S_EMIT;
                end else if (!st.rd_zero) begin
                    cmd.rd_issue = 1'b1;
                end
            end
            S_REMOVE: begin
                cmd.rm_take = st.rd_pend;
                if (st.rd_at_count && !st.rd_pend) begin
                    cmd.set_count = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = ssym_pkg::RES_REMOVE;
                    state_next    = S_EMIT;
                end else if (!st.rd_at_count) begin
                    cmd.rd_issue = 1'b1;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[hw/rtl/scoped_symbol_table.sv]
// Top level of the scoped symbol table: stream ports, controller and datapath.
// Define and unused codes are settled in the execute state and then emitted.
// Lookup scans the stored entries from the newest down until a hit, and remove scans them all;
// both scan the entry memory through its single read port.
// One transaction is in progress at a time; a new one is accepted while a result waits.
// Synchronous active-low reset empties the table; memory contents are not cleared.
module scoped_symbol_table #(
    parameter int ENTRIES = ssym_pkg::ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // sym_id[15:0], sym_type[23:16], sym_offset[39:24],
                                  // sym_depth[47:40]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // found_type[7:0], found_offset[23:8], found_depth[31:24],
                                  // removed_count[38:32], zero[39]
    output logic [1:0]  m_tuser   // status[1:0]
);

    ssym_pkg::dp_cmd_t    cmd;
    ssym_pkg::dp_status_t st;
    ssym_pkg::entry_t     in_entry;
    ssym_pkg::result_t    out_result;

    assign in_entry.sym_id     = s_tdata[15:0];
    assign in_entry.sym_type   = s_tdata[23:16];
    assign in_entry.sym_offset = s_tdata[39:24];
    assign in_entry.sym_depth  = s_tdata[47:40];

    ssym_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    ssym_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .in_func    (s_tuser),
        .in_entry   (in_entry),
        .out_result (out_result)
    );

    assign m_tdata = {1'b0, out_result.removed_count, out_result.found_depth,
                      out_result.found_offset, out_result.found_type};
    assign m_tuser = out_result.status;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in progress");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_define |-> !st.full)
        else $error("define written into a full table");

    a_full_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ssym_pkg::ST_FULL)) |-> (m_tdata == '0))
        else $error("full status with nonzero payload");

    a_miss_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ssym_pkg::ST_NOT_FOUND)) |-> (m_tdata == '0))
        else $error("not-found status with nonzero payload");

endmodule

[test/scoped_symbol_table_tb.sv]
// Self-checking testbench for the scoped symbol table with stream-side traffic and stalls.
`timescale 1ns / 100ps

module scoped_symbol_table_tb;

    localparam logic [ssym_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_TOTAL = 550;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = ssym_pkg::ENTRIES_DEFAULT + 16;
    localparam int CYCLE_LIMIT = 400000;

    class scope_table_scoreboard;
        ssym_pkg::entry_t  entries[$];
        ssym_pkg::result_t expected[$];
        int errors, checked;
        int n_define, n_full, n_hit, n_miss, n_remove, n_unused, max_removed;

        function int pending();
            return expected.size();
        endfunction

        function void note_request(logic [ssym_pkg::FUNC_W-1:0] func,
                                   ssym_pkg::entry_t req);
            ssym_pkg::result_t want;
            ssym_pkg::entry_t  kept[$];
            int                gone;
            bit                hit;
            want = '0;
            gone = 0;
            hit = 1'b0;
            case (func)
                ssym_pkg::OP_DEFINE: begin
                    if (entries.size() >= ssym_pkg::ENTRIES_DEFAULT) begin
                        want.status = ssym_pkg::ST_FULL;
                        n_full++;
                    end else begin
                        entries.push_back(req);
                        want.status = ssym_pkg::ST_OK;
                        want.found_type = req.sym_type;
                        want.found_offset = req.sym_offset;
                        want.found_depth = req.sym_depth;
                        n_define++;
                    end
                end
                ssym_pkg::OP_LOOKUP: begin
                    for (int i = entries.size() - 1; i >= 0 && !hit; i--) begin
                        if (entries[i].sym_id == req.sym_id) begin
                            hit = 1'b1;
                            want.status = ssym_pkg::ST_OK;
                            want.found_type = entries[i].sym_type;
                            want.found_offset = entries[i].sym_offset;
                            want.found_depth = entries[i].sym_depth;
                        end
                    end
                    if (hit) begin
                        n_hit++;
                    end else begin
                        want.status = ssym_pkg::ST_NOT_FOUND;
                        n_miss++;
                    end
                end
                ssym_pkg::OP_REMOVE: begin
                    foreach (entries[i]) begin
                        if (entries[i].sym_depth == req.sym_depth) begin
                            gone++;
                        end else begin
                            kept.push_back(entries[i]);
                        end
                    end
                    entries = kept;
                    want.status = ssym_pkg::ST_OK;
                    want.removed_count = gone[ssym_pkg::REMOVED_W-1:0];
                    if (gone > max_removed) begin
                        max_removed = gone;
                    end
                    n_remove++;
                end
                default: begin
                    want.status = ssym_pkg::ST_OK;
                    n_unused++;
                end
            endcase
            expected.push_back(want);
        endfunction

        function void check_reply(ssym_pkg::result_t got);
            ssym_pkg::result_t want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] result with nothing outstanding:", $realtime);
                    $display("             st=%0d ty=%h off=%h dep=%h rm=%0d",
                             got.status, got.found_type, got.found_offset,
                             got.found_depth, got.removed_count);
                end
                return;
            end
            want = expected.pop_front();
            checked++;
            if (got.status != want.status || got.found_type != want.found_type ||
                got.found_offset != want.found_offset || got.found_depth != want.found_depth ||
                got.removed_count != want.removed_count) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] result %0d mismatch:", $realtime, checked);
                    $display("             expected st=%0d ty=%h off=%h dep=%h rm=%0d",
                             want.status, want.found_type, want.found_offset,
                             want.found_depth, want.removed_count);
                    $display("             got      st=%0d ty=%h off=%h dep=%h rm=%0d",
                             got.status, got.found_type, got.found_offset,
                             got.found_depth, got.removed_count);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    scope_table_scoreboard sb;
    int items_sent = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int cycle_count = 0;
    logic [ssym_pkg::ID_W-1:0] id_pool[16];

    scoped_symbol_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending());
            $display("** scoped_symbol_table: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        ssym_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.found_type = m_tdata[7:0];
            got.found_offset = m_tdata[23:8];
            got.found_depth = m_tdata[31:24];
            got.removed_count = m_tdata[38:32];
            sb.check_reply(got);
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    function automatic ssym_pkg::entry_t make_entry(int id, int ty, int off, int dep);
        ssym_pkg::entry_t e;
        e.sym_id = ssym_pkg::ID_W'(id);
        e.sym_type = ssym_pkg::TYPE_W'(ty);
        e.sym_offset = ssym_pkg::OFFSET_W'(off);
        e.sym_depth = ssym_pkg::DEPTH_W'(dep);
        return e;
    endfunction

    function automatic logic [ssym_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 4) != 0) begin
            return id_pool[4'($urandom_range(0, 15))];
        end
        return ssym_pkg::ID_W'($urandom_range(0, 65535));
    endfunction

    task automatic offer(input logic [ssym_pkg::FUNC_W-1:0] func, input ssym_pkg::entry_t e);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata <= e;
        s_tuser <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(func, e);
        burst_left--;
        items_sent++;
    endtask

    task automatic random_define(input int dep);
        offer(ssym_pkg::OP_DEFINE, make_entry(pick_id(), $urandom_range(0, 255),
                                              $urandom_range(0, 65535), dep));
    endtask

    task automatic random_lookup();
        offer(ssym_pkg::OP_LOOKUP, make_entry(pick_id(), $urandom_range(0, 255),
                                              $urandom_range(0, 65535),
                                              $urandom_range(0, 255)));
    endtask

    task automatic purge_depth(input int dep);
        offer(ssym_pkg::OP_REMOVE, make_entry($urandom_range(0, 65535), $urandom_range(0, 255),
                                              $urandom_range(0, 65535), dep));
    endtask

    task automatic fill_then_purge(input bit drain_first);
        int dep;
        dep = $urandom_range(0, 255);
        if (drain_first) begin
            while (sb.entries.size() > 0) begin
                purge_depth(sb.entries[0].sym_depth);
            end
        end
        while (sb.entries.size() < ssym_pkg::ENTRIES_DEFAULT) begin
            random_define(dep);
        end
        repeat (3) random_define($urandom_range(0, 255));
        repeat (6) random_lookup();
        purge_depth(dep);
    endtask

    initial begin
        int level;
        int roll;
        int fill_step;
        sb = new();
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++) begin
            id_pool[i] = ssym_pkg::ID_W'($urandom_range(0, 65535));
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h0000, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_REMOVE, make_entry(16'h0000, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'h0000, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'h1234, 8'h11, 16'h0100, 8'h01));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'h1234, 8'h22, 16'h0200, 8'h02));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h1234, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'hFFFF, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h0000, 8'hFF, 16'hFFFF, 8'hFF));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h5555, 8'h00, 16'h0000, 8'h00));
        offer(OP_UNUSED, make_entry(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h1234, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_REMOVE, make_entry(16'h0000, 8'h00, 16'h0000, 8'h02));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'h1234, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_REMOVE, make_entry(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'hFFFF, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'hAAAA, 8'h55, 16'hAAAA, 8'h01));
        offer(ssym_pkg::OP_DEFINE, make_entry(16'h5555, 8'hAA, 16'h5555, 8'h01));
        offer(ssym_pkg::OP_REMOVE, make_entry(16'h0000, 8'h00, 16'h0000, 8'h01));
        offer(ssym_pkg::OP_LOOKUP, make_entry(16'hAAAA, 8'h00, 16'h0000, 8'h00));
        offer(ssym_pkg::OP_REMOVE, make_entry(16'h0000, 8'h00, 16'h0000, 8'h00));
        offer(OP_UNUSED, make_entry(16'h0000, 8'h00, 16'h0000, 8'h00));

        // The receiver stops for a long stretch while new transactions keep arriving.
        hold_requests++;
        level = 0;
        fill_step = 0;
        while (items_sent < ITEMS_TOTAL) begin
            if (fill_step < 3 && items_sent >= 150 * (fill_step + 1)) begin
                fill_then_purge(fill_step != 1);
                fill_step++;
                level = 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                random_define(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : level);
            end else if (roll < 75) begin
                random_lookup();
            end else if (roll < 85) begin
                if (level < 12) begin
                    level++;
                end
                random_define(level);
            end else if (roll < 95) begin
                purge_depth(level);
                if (level > 0) begin
                    level--;
                end
            end else if (roll < 98) begin
                purge_depth($urandom_range(0, 255));
            end else begin
                offer(OP_UNUSED, make_entry($urandom_range(0, 65535), $urandom_range(0, 255),
                                            $urandom_range(0, 65535), $urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d transactions: %0d defines, %0d refused on a full table,",
                 items_sent, sb.n_define, sb.n_full);
        $display("%0d lookups (%0d misses), %0d scope purges (largest %0d entries),",
                 sb.n_hit + sb.n_miss, sb.n_miss, sb.n_remove, sb.max_removed);
        $display("%0d unused opcodes, %0d results checked.", sb.n_unused, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** scoped_symbol_table: PASSED **");
        end else begin
            $display("Errors: %0d, results still outstanding: %0d.", sb.errors, sb.pending());
            $display("** scoped_symbol_table: FAILED **");
        end
        $finish;
    end
endmodule
